/* src/iis_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iis_pkg
// shared types and codes for the integer interval set unit
// ----------------------------------------------------------------------------
package iis_pkg;

	typedef enum logic [1:0] {
		OP_ADD   = 2'd0,
		OP_POINT = 2'd1,
		OP_RANGE = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_SCAN  = 7'b0000010,
		ST_DEC   = 7'b0000100,
		ST_COPY  = 7'b0001000,
		ST_SWAP  = 7'b0010000,
		ST_SUM   = 7'b0100000,
		ST_OUT   = 7'b1000000
	} state_t;

	typedef struct packed {
		logic        hit;
		logic        changed;
		logic        overflow;
		logic [4:0]  range_count;
		logic        set_empty;
		logic [31:0] set_min;
		logic [31:0] set_max;
		logic [31:0] total_size;
	} result_t;

	localparam logic [32:0] SAT_MAX = 33'h0_FFFF_FFFF;

endpackage

/* src/iis_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iis_ram
// generic single-port-write, single-port-read ram with registered read
// ----------------------------------------------------------------------------
module iis_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* src/integer_interval_set_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_interval_set_unit
// sorted table of disjoint signed 32-bit ranges with merge on insert
// ----------------------------------------------------------------------------
// usage:
//  input channel (valid/ready) takes op, first_bound, second_bound; op add
//  merges a range into the set, point and range ops test membership.
//  one result transaction per input on the output channel, with a summary of
//  the whole set (count, min, max, empty, saturated total size).
//  the table sits in two ping-pong rams (low/high pairs); a scan pass reads
//  every stored entry to decide cover and merge, a copy pass writes the new
//  table into the other bank, and a sum pass totals the sizes.
//  a query or an add that leaves the table alone runs the scan pass and then
//  the sum pass; an add that rewrites the table runs the copy pass between
//  them (one ram read per cycle in each pass); one item is worked on at a
//  time.
//  reset empties the set at once (entry count zero, no ram clearing).
//  the result is held in an output register; the next input is taken as soon
//  as the previous result leaves, and a stalled receiver simply holds it.
// ----------------------------------------------------------------------------
module integer_interval_set_unit #(
	parameter int MAX_RANGES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  op,
	input  logic signed [31:0] first_bound,
	input  logic signed [31:0] second_bound,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        hit,
	output logic        changed,
	output logic        overflow,
	output logic [4:0]  range_count,
	output logic        set_empty,
	output logic signed [31:0] set_min,
	output logic signed [31:0] set_max,
	output logic [31:0] total_size
);

	localparam int AW = $clog2(MAX_RANGES);
	localparam int CW = $clog2(MAX_RANGES + 1);
	localparam logic [CW-1:0] CMAX = CW'(MAX_RANGES);

	iis_pkg::state_t state_q;
	logic          bank_q;
	logic [CW-1:0] cnt_q, ncnt_q, idx_q;
	logic          rvalid_q;
	logic [CW-1:0] ridx_q;
	iis_pkg::op_t  op_q;
	logic signed [32:0] lo_q, hi_q, mlo_q, mhi_q;
	logic          cov_q, merged_q, placed_q, pend_q;
	logic signed [31:0] pl_q, ph_q, first_q;
	logic [32:0]   total_q;
	logic          out_valid_q;
	iis_pkg::result_t res_q;

	logic [1:0]    we;
	logic [AW-1:0] waddr, raddr;
	logic [63:0]   wdata;
	logic [63:0]   rdata [2];

	for (genvar g = 0; g < 2; g++) begin : g_bank
		iis_ram #(.WIDTH(64), .DEPTH(MAX_RANGES)) u_ram (
			.clk(clk), .we(we[g]), .waddr(waddr), .wdata(wdata),
			.raddr(raddr), .rdata(rdata[g]));
	end

	logic signed [32:0] el, eh;
	logic touch;
	assign el = 33'(signed'(rdata[bank_q][63:32]));
	assign eh = 33'(signed'(rdata[bank_q][31:0]));
	assign touch = (eh + 33'sd1 >= lo_q) && (el - 33'sd1 <= hi_q);
	assign raddr = idx_q[AW-1:0];

	logic signed [31:0] a_in, b_in;
	assign a_in = first_bound;
	assign b_in = second_bound;

	assign in_ready = (state_q == iis_pkg::ST_IDLE) && !out_valid_q;

	// write port of the destination bank during copy and swap
	logic          do_wr;
	logic signed [31:0] wl, wh;
	always_comb begin
		do_wr = 1'b0;
		wl = '0;
		wh = '0;
		if (state_q == iis_pkg::ST_COPY && rvalid_q) begin
			if (!touch) begin
				do_wr = 1'b1;
				if (pend_q) begin
					wl = pl_q;
					wh = ph_q;
				end else if (!placed_q && el > mhi_q) begin
					wl = mlo_q[31:0];
					wh = mhi_q[31:0];
				end else begin
					wl = el[31:0];
					wh = eh[31:0];
				end
			end
		end else if (state_q == iis_pkg::ST_SWAP && (pend_q || !placed_q)) begin
			do_wr = 1'b1;
			wl = pend_q ? pl_q : mlo_q[31:0];
			wh = pend_q ? ph_q : mhi_q[31:0];
		end
	end
	assign wdata = {wl, wh};
	assign waddr = ncnt_q[AW-1:0];
	assign we[0] = do_wr && bank_q;
	assign we[1] = do_wr && !bank_q;

	logic [32:0] tsum;
	assign tsum = total_q + 33'(eh - el + 33'sd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= iis_pkg::ST_IDLE;
			bank_q      <= 1'b0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			rvalid_q    <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				iis_pkg::ST_IDLE: begin
					if (in_valid && in_ready) begin
						op_q     <= iis_pkg::op_t'(op);
						first_q  <= a_in;
						lo_q     <= (a_in < b_in) ? 33'(a_in) : 33'(b_in);
						hi_q     <= (a_in < b_in) ? 33'(b_in) : 33'(a_in);
						mlo_q    <= (a_in < b_in) ? 33'(a_in) : 33'(b_in);
						mhi_q    <= (a_in < b_in) ? 33'(b_in) : 33'(a_in);
						cov_q    <= 1'b0;
						merged_q <= 1'b0;
						idx_q    <= '0;
						rvalid_q <= 1'b0;
						state_q  <= iis_pkg::ST_SCAN;
					end
				end
				iis_pkg::ST_SCAN: begin
					if (op_q == iis_pkg::OP_POINT) begin
						lo_q <= 33'(first_q);
						hi_q <= 33'(first_q);
					end
					rvalid_q <= idx_q < cnt_q;
					ridx_q   <= idx_q;
					idx_q    <= idx_q + CW'(1);
					if (rvalid_q) begin
						if (lo_q >= el && hi_q <= eh) cov_q <= 1'b1;
						if (touch) begin
							merged_q <= 1'b1;
							if (el < mlo_q) mlo_q <= el;
							if (eh > mhi_q) mhi_q <= eh;
						end
					end
					if (idx_q >= cnt_q && !(idx_q == '0 && !rvalid_q && cnt_q != '0)) begin
						if (!(idx_q < cnt_q)) state_q <= iis_pkg::ST_DEC;
					end
				end
				iis_pkg::ST_DEC: begin
					idx_q    <= '0;
					rvalid_q <= 1'b0;
					ncnt_q   <= '0;
					placed_q <= 1'b0;
					pend_q   <= 1'b0;
					total_q  <= '0;
					res_q.hit      <= (op_q != iis_pkg::OP_NONE) && cov_q;
					res_q.changed  <= 1'b0;
					res_q.overflow <= 1'b0;
					if (op_q == iis_pkg::OP_ADD && !cov_q) begin
						if (!merged_q && cnt_q >= CMAX) begin
							res_q.overflow <= 1'b1;
							state_q <= iis_pkg::ST_SUM;
						end else begin
							res_q.changed <= 1'b1;
							state_q <= iis_pkg::ST_COPY;
						end
					end else begin
						state_q <= iis_pkg::ST_SUM;
					end
				end
				iis_pkg::ST_COPY: begin
					rvalid_q <= idx_q < cnt_q;
					idx_q    <= idx_q + CW'(1);
					// once the merged range is out, entries trail by one slot
					if (do_wr) begin
						ncnt_q <= ncnt_q + CW'(1);
						if (pend_q || (!placed_q && el > mhi_q)) begin
							placed_q <= 1'b1;
							pend_q   <= 1'b1;
							pl_q     <= el[31:0];
							ph_q     <= eh[31:0];
						end
					end
					if (cnt_q == '0 || (rvalid_q && idx_q >= cnt_q)) begin
						state_q <= iis_pkg::ST_SWAP;
					end
				end
				iis_pkg::ST_SWAP: begin
					if (do_wr) ncnt_q <= ncnt_q + CW'(1);
					if (pend_q) begin
						pend_q <= 1'b0;
					end else begin
						placed_q <= 1'b1;
						bank_q   <= !bank_q;
						cnt_q    <= do_wr ? ncnt_q + CW'(1) : ncnt_q;
						idx_q    <= '0;
						rvalid_q <= 1'b0;
						total_q  <= '0;
						state_q  <= iis_pkg::ST_SUM;
					end
				end
				iis_pkg::ST_SUM: begin
					rvalid_q <= idx_q < cnt_q;
					ridx_q   <= idx_q;
					idx_q    <= idx_q + CW'(1);
					if (rvalid_q) begin
						total_q <= (tsum > iis_pkg::SAT_MAX) ? iis_pkg::SAT_MAX : tsum;
						if (ridx_q == '0) res_q.set_min <= el[31:0];
						if (ridx_q == cnt_q - CW'(1)) res_q.set_max <= eh[31:0];
					end
					if (cnt_q == '0 || (rvalid_q && idx_q >= cnt_q)) begin
						state_q <= iis_pkg::ST_OUT;
					end
				end
				iis_pkg::ST_OUT: begin
					res_q.range_count <= 5'(cnt_q);
					res_q.set_empty   <= cnt_q == '0;
					res_q.total_size  <= total_q[31:0];
					if (cnt_q == '0) begin
						res_q.set_min <= '0;
						res_q.set_max <= '0;
					end
					out_valid_q <= 1'b1;
					state_q     <= iis_pkg::ST_IDLE;
				end
				default: state_q <= iis_pkg::ST_IDLE;
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign hit         = res_q.hit;
	assign changed     = res_q.changed;
	assign overflow    = res_q.overflow;
	assign range_count = res_q.range_count;
	assign set_empty   = res_q.set_empty;
	assign set_min     = res_q.set_min;
	assign set_max     = res_q.set_max;
	assign total_size  = res_q.total_size;

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != iis_pkg::ST_IDLE) |-> !in_ready)
		else $error("input taken while busy");
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CMAX)
		else $error("entry count above table size");
	a_flags_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(res_q.changed && res_q.overflow))
		else $error("changed and overflow together");
	a_empty_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (res_q.set_empty == (cnt_q == '0)))
		else $error("empty flag mismatch");

endmodule

/* tb/integer_interval_set_unit_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_interval_set_unit_test
// self-checking bench for the integer interval set unit: a behavioral copy of
// the range table predicts every result, which is compared field by field with
// the result transactions under random sender idling and receiver stalls
// ----------------------------------------------------------------------------
module integer_interval_set_unit_test;

	localparam int NR = 16;

	typedef struct {
		logic        hit;
		logic        changed;
		logic        overflow;
		logic [4:0]  range_count;
		logic        set_empty;
		logic [31:0] set_min;
		logic [31:0] set_max;
		logic [31:0] total_size;
	} summary_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] op = iis_pkg::OP_ADD;
	logic signed [31:0] first_bound = '0;
	logic signed [31:0] second_bound = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic hit, changed, overflow, set_empty;
	logic [4:0] range_count;
	logic signed [31:0] set_min, set_max;
	logic [31:0] total_size;

	integer_interval_set_unit #(.MAX_RANGES(NR)) u_dut (.*);

	always #1 clk = ~clk;

	longint tbl_lo[NR];
	longint tbl_hi[NR];
	int tbl_n = 0;
	summary_t pending[$];
	int errors = 0;
	int send_idle = 0;
	int recv_stall = 0;
	bit hold_recv = 1'b0;

	function automatic bit table_covers(longint lo, longint hi);
		for (int i = 0; i < tbl_n; i++)
			if (lo >= tbl_lo[i] && hi <= tbl_hi[i])
				return 1'b1;
		return 1'b0;
	endfunction

	function automatic summary_t apply_transaction(iis_pkg::op_t o,
			logic signed [31:0] a, logic signed [31:0] b);
		summary_t r;
		longint lo, hi, mlo, mhi, total;
		longint nl[NR], nh[NR];
		int n, merged;
		bit placed;
		r = '{default: '0};
		lo = (a < b) ? a : b;
		hi = (a < b) ? b : a;
		case (o)
			iis_pkg::OP_ADD: begin
				if (table_covers(lo, hi)) begin
					r.hit = 1'b1;
				end else begin
					mlo = lo; mhi = hi; merged = 0;
					for (int i = 0; i < tbl_n; i++)
						if (tbl_hi[i] + 1 >= lo && tbl_lo[i] - 1 <= hi) begin
							if (tbl_lo[i] < mlo) mlo = tbl_lo[i];
							if (tbl_hi[i] > mhi) mhi = tbl_hi[i];
							merged++;
						end
					if (merged == 0 && tbl_n >= NR) begin
						r.overflow = 1'b1;
					end else begin
						n = 0; placed = 1'b0;
						for (int i = 0; i < tbl_n; i++) begin
							if (tbl_hi[i] + 1 >= lo && tbl_lo[i] - 1 <= hi) continue;
							if (!placed && tbl_lo[i] > mhi) begin
								nl[n] = mlo; nh[n] = mhi; n++; placed = 1'b1;
							end
							nl[n] = tbl_lo[i]; nh[n] = tbl_hi[i]; n++;
						end
						if (!placed) begin
							nl[n] = mlo; nh[n] = mhi; n++;
						end
						tbl_lo = nl; tbl_hi = nh; tbl_n = n;
						r.changed = 1'b1;
					end
				end
			end
			iis_pkg::OP_POINT: r.hit = table_covers(longint'(a), longint'(a));
			iis_pkg::OP_RANGE: r.hit = table_covers(lo, hi);
			default: ;
		endcase
		total = 0;
		for (int i = 0; i < tbl_n; i++)
			total += tbl_hi[i] - tbl_lo[i] + 1;
		r.total_size = (total > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : total[31:0];
		r.range_count = tbl_n[4:0];
		r.set_empty = (tbl_n == 0);
		if (tbl_n > 0) begin
			r.set_min = tbl_lo[0][31:0];
			r.set_max = tbl_hi[tbl_n - 1][31:0];
		end
		return r;
	endfunction

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		$display("error: %s got %h expected %h", what, got, want);
		errors++;
	endtask

	// one input transaction, with random idle ahead of it
	task automatic send(iis_pkg::op_t o, logic signed [31:0] a, logic signed [31:0] b);
		if (send_idle > 0 && $urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < send_idle);
		end
		op <= o;
		first_bound <= a;
		second_bound <= b;
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		pending.insert(pending.size(), apply_transaction(o, a, b));
	endtask

	task automatic drain();
		int guard;
		guard = 0;
		in_valid <= 1'b0;
		while (pending.size() > 0 && guard < 100000) begin
			@(posedge clk);
			guard++;
		end
		repeat (80) @(posedge clk);
	endtask

	always @(posedge clk) begin
		if (hold_recv)
			out_ready <= 1'b0;
		else
			out_ready <= !(recv_stall > 0 && $urandom_range(99) < recv_stall);
	end

	always @(posedge clk) begin
		summary_t e;
		if (arst_n && out_valid && out_ready) begin
			if (pending.size() == 0) begin
				report("unexpected transaction", '0, '0);
			end else begin
				e = pending.pop_front();
				if (hit !== e.hit) report("hit", hit, e.hit);
				if (changed !== e.changed) report("changed", changed, e.changed);
				if (overflow !== e.overflow) report("overflow", overflow, e.overflow);
				if (range_count !== e.range_count)
					report("range_count", range_count, e.range_count);
				if (set_empty !== e.set_empty) report("set_empty", set_empty, e.set_empty);
				if (set_min !== e.set_min) report("set_min", set_min, e.set_min);
				if (set_max !== e.set_max) report("set_max", set_max, e.set_max);
				if (total_size !== e.total_size)
					report("total_size", total_size, e.total_size);
			end
		end
	end

	function automatic logic signed [31:0] rand_bound();
		case ($urandom_range(3))
			0: return $urandom;
			1: return $signed($urandom_range(200)) - 100;
			2: return ($urandom_range(1)) ? 32'sh7FFF_FFF0 + $urandom_range(15)
				: 32'sh8000_0000 + $urandom_range(15);
			default: return $signed($urandom_range(2000)) - 1000;
		endcase
	endfunction

	function automatic iis_pkg::op_t rand_op();
		int k;
		k = $urandom_range(99);
		if (k < 45) return iis_pkg::OP_ADD;
		if (k < 70) return iis_pkg::OP_POINT;
		if (k < 97) return iis_pkg::OP_RANGE;
		return iis_pkg::OP_NONE;
	endfunction

	task automatic test_directed();
		send(iis_pkg::OP_POINT, 0, 0);
		send(iis_pkg::OP_RANGE, 5, -5);
		send(iis_pkg::OP_NONE, 32'sh7FFF_FFFF, 32'sh8000_0000);
		send(iis_pkg::OP_ADD, 20, 10);
		send(iis_pkg::OP_ADD, 12, 15);
		send(iis_pkg::OP_ADD, 21, 30);
		send(iis_pkg::OP_ADD, 0, 8);
		send(iis_pkg::OP_ADD, 9, 9);
		send(iis_pkg::OP_POINT, 30, 0);
		send(iis_pkg::OP_POINT, 31, 0);
		send(iis_pkg::OP_RANGE, 30, 0);
		send(iis_pkg::OP_RANGE, 0, 31);
		send(iis_pkg::OP_ADD, 32'sh8000_0000, 32'sh8000_0000);
		send(iis_pkg::OP_ADD, 32'sh7FFF_FFFF, 32'sh7FFF_FFFE);
		send(iis_pkg::OP_ADD, 32'sh7FFF_FFFF, 32'sh8000_0000);
		send(iis_pkg::OP_RANGE, 32'sh7FFF_FFFF, 32'sh8000_0000);
		send(iis_pkg::OP_NONE, 1, 2);
		send(iis_pkg::OP_POINT, 32'shFFFF_FFFF, 32'sh5555_5555);
		drain();
	endtask

	task automatic test_overflow();
		for (int i = 0; i < NR + 3; i++)
			send(iis_pkg::OP_ADD, 1000 * i + 100, 1000 * i + 110);
		send(iis_pkg::OP_ADD, 50, 50);
		send(iis_pkg::OP_ADD, 111, 111);
		send(iis_pkg::OP_ADD, -5, 32'sh7FFF_0000);
		drain();
	endtask

	task automatic test_random(int count, int s_idle, int r_stall);
		send_idle = s_idle;
		recv_stall = r_stall;
		for (int i = 0; i < count; i++)
			send(rand_op(), rand_bound(), rand_bound());
		drain();
		send_idle = 0;
		recv_stall = 0;
	endtask

	task automatic test_backpressure();
		hold_recv = 1'b1;
		fork
			begin
				repeat (300) @(posedge clk);
				hold_recv = 1'b0;
			end
			for (int i = 0; i < 30; i++)
				send(rand_op(), rand_bound(), rand_bound());
		join
		drain();
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_overflow();
		test_random(220, 0, 0);
		test_random(220, 69, 0);
		test_random(220, 0, 69);
		test_random(200, 7, 7);
		test_backpressure();
		if (errors == 0 && pending.size() == 0)
			$display("integer_interval_set_unit: match");
		else
			$display("integer_interval_set_unit: mismatch");
		$finish;
	end

	initial begin
		#2000000;
		$display("integer_interval_set_unit: mismatch");
		$finish;
	end

endmodule
